FILE: hw/rtl/icbr_pkg.sv
package icbr_pkg;

   // input word modes
   localparam logic [1:0] MODE_FRAME = 2'd0;
   localparam logic [1:0] MODE_HOST  = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // result actions
   localparam logic [3:0] ACT_ATS      = 4'd0;
   localparam logic [3:0] ACT_FORWARD  = 4'd1;
   localparam logic [3:0] ACT_I_REPLY  = 4'd2;
   localparam logic [3:0] ACT_R_ACK    = 4'd3;
   localparam logic [3:0] ACT_RESEND   = 4'd4;
   localparam logic [3:0] ACT_PPS      = 4'd5;
   localparam logic [3:0] ACT_DESELECT = 4'd6;
   localparam logic [3:0] ACT_WTX      = 4'd7;
   localparam logic [3:0] ACT_REPORT   = 4'd8;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_CRC     = 3'd1;
   localparam logic [2:0] ST_SHORT   = 3'd2;
   localparam logic [2:0] ST_NAK     = 3'd3;
   localparam logic [2:0] ST_STRAY   = 3'd4;
   localparam logic [2:0] ST_IGNORED = 3'd5;

   // frame bytes and masks
   localparam logic [7:0] CMD_ATS_REQ  = 8'hE0;
   localparam logic [7:0] PCB_WTX      = 8'hF2;
   localparam logic [7:0] CLS_MASK     = 8'hE0;
   localparam logic [7:0] CLS_I        = 8'h00;
   localparam logic [7:0] CLS_R        = 8'hA0;
   localparam logic [7:0] CLS_S        = 8'hC0;
   localparam logic [3:0] NIB_PPS      = 4'hD;
   localparam logic [3:0] NIB_R_NAK    = 4'hB;
   localparam logic [7:0] PCB_R_ACK    = 8'hA3;
   localparam logic [6:0] PCB_I_BASE   = 7'h01;
   localparam logic [7:0] S_DESEL      = 8'hC2;
   localparam logic [7:0] S_DESEL_CID  = 8'hCA;
   localparam logic [7:0] ATS_TL       = 8'd20;

   localparam logic [8:0] LEN_ATS      = 9'd22;
   localparam logic [8:0] LEN_SHORT    = 9'd3;
   localparam logic [8:0] LEN_WTX      = 9'd4;
   localparam logic [8:0] LEN_CRC      = 9'd2;

   localparam logic [1:0] CSR_ADDR_W   = 2'd3;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] tx_first_byte;
      logic [1:0] payload_offset;
      logic [8:0] byte_count;
      logic [2:0] status;
      logic       last;
   } rsp_word_type;

   function automatic rsp_word_type mk_word(input logic [3:0] action,
                                            input logic [7:0] tx,
                                            input logic [1:0] off,
                                            input logic [8:0] cnt,
                                            input logic [2:0] status);
      rsp_word_type w;
      w.action         = action;
      w.tx_first_byte  = tx;
      w.payload_offset = off;
      w.byte_count     = cnt;
      w.status         = status;
      w.last           = 1'b0;
      return w;
   endfunction

   function automatic rsp_word_type mk_report(input logic [7:0] fb,
                                              input logic [2:0] status);
      return mk_word(ACT_REPORT, fb, 2'd1, 9'd0, status);
   endfunction

endpackage

FILE: hw/rtl/icbr_if.sv
interface icbr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic [8:0] frame_length;
   logic       crc_match;
   logic [8:0] host_length;

   modport source(output valid, mode, first_byte, second_byte, frame_length, crc_match,
                  host_length, input ready);
   modport sink(input valid, mode, first_byte, second_byte, frame_length, crc_match,
                host_length, output ready);
endinterface

interface icbr_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] action;
   logic [7:0] tx_first_byte;
   logic [1:0] payload_offset;
   logic [8:0] byte_count;
   logic [2:0] status;
   logic       last;

   modport source(output valid, action, tx_first_byte, payload_offset, byte_count, status,
                  last, input ready);
   modport sink(input valid, action, tx_first_byte, payload_offset, byte_count, status,
                last, output ready);
endinterface

FILE: hw/rtl/iso14443_4_card_block_responder.sv
// Card-side block protocol responder (ISO 14443-4 style transmission protocol).
//
// req_ch  : one word per event - a received reader frame summary, a host response
//           ready to go, or a wait tick. Accepted when valid and ready are high.
// rsp_ch  : transmit commands and reports, zero to two words per request word; the
//           final word of each request carries last.
// csr_*   : APB-style port, one register at byte address 0 (WTX interval, ticks).
//
// Ordering: a request word's results are registered into the result queue and leave it
//   behind any older words. Throughput: one request word per cycle while req_ch.ready
//   is high. Decisions depend only on the registered protocol flags, so each word is
//   resolved in a single pass of logic straight into a four-word result queue.
// Stalls: the result queue decouples the two sides. req_ch.ready is high while the
//   queue has room for two words, so a stalled receiver lets at most four words of
//   results pile up before requests are held off; nothing is ever dropped.
// Reset (synchronous): block number 1, no I-block seen, card id 0, not waiting,
//   queue empty, WTX interval 3600 ticks. No clearing pass is needed.
module iso14443_4_card_block_responder #(
   parameter int APDU_BUFFER_BYTES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   icbr_req_if.sink                      req_ch,
   icbr_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [icbr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam logic [8:0] APDU_MAX = 9'(APDU_BUFFER_BYTES);

   function automatic logic [8:0] cap_apdu(input logic [8:0] x);
      return (x > APDU_MAX) ? APDU_MAX : x;
   endfunction

   // I reply: PCB carries the block number, length is header + APDU + CRC
   function automatic icbr_pkg::rsp_word_type i_reply(input logic bn, input logic hdr2,
                                                      input logic [8:0] apdu);
      logic [1:0] hdr;
      hdr = {hdr2, ~hdr2};
      return icbr_pkg::mk_word(icbr_pkg::ACT_I_REPLY, {icbr_pkg::PCB_I_BASE, bn}, hdr,
                               cap_apdu(apdu) + {7'd0, hdr} + icbr_pkg::LEN_CRC,
                               icbr_pkg::ST_OK);
   endfunction

   // ---------------- configuration ----------------
   logic [15:0] wtx_interval_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {16'd0, wtx_interval_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         wtx_interval_ff <= 16'd3600;
      end else if (csr_wr) begin
         wtx_interval_ff <= csr_pwdata[15:0];
      end
   end

   // ---------------- protocol state ----------------
   logic        block_number_ff, block_number_in;
   logic        iblock_seen_ff, iblock_seen_in;
   logic [3:0]  card_id_ff, card_id_in;
   logic        waiting_ff, waiting_in;
   logic        wtx_pending_ff, wtx_pending_in;
   logic        host_ready_ff, host_ready_in;
   logic [8:0]  host_len_ff, host_len_in;
   logic [15:0] wait_count_ff, wait_count_in;
   logic        hdr2_ff, hdr2_in;          // header is two bytes (NAD present)
   logic [7:0]  last_tx_first_ff, last_tx_first_in;
   logic [8:0]  last_tx_len_ff, last_tx_len_in;

   // ---------------- result queue ----------------
   icbr_pkg::rsp_word_type fifo_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        take, pop;

   assign req_ch.ready = (count_ff <= 3'd2);
   assign take         = req_ch.valid & req_ch.ready;
   assign pop          = rsp_ch.valid & rsp_ch.ready;

   logic [7:0] fb, sb;
   logic [8:0] flen;
   assign fb   = req_ch.first_byte;
   assign sb   = req_ch.second_byte;
   assign flen = req_ch.frame_length;

   // ---------------- frame dispatch (not waiting, or after a NAK abort) ----------------
   icbr_pkg::rsp_word_type disp_w0, disp_w1;
   logic       disp_two;          // empty APDU: forward plus immediate I reply
   logic       disp_start_wait;
   logic       disp_bn, disp_seen, disp_hdr2;
   logic [3:0] disp_cid;
   logic [7:0] disp_tx_first;
   logic [8:0] disp_tx_len;
   logic [1:0] i_hdr;
   logic [8:0] i_apdu;

   always_comb begin
      disp_w0         = icbr_pkg::mk_report(fb, icbr_pkg::ST_IGNORED);
      disp_w1         = disp_w0;
      disp_two        = 1'b0;
      disp_start_wait = 1'b0;
      disp_bn         = block_number_ff;
      disp_seen       = iblock_seen_ff;
      disp_hdr2       = hdr2_ff;
      disp_cid        = card_id_ff;
      disp_tx_first   = last_tx_first_ff;
      disp_tx_len     = last_tx_len_ff;
      i_hdr           = {fb[2], ~fb[2]};
      i_apdu          = (flen > {7'd0, i_hdr} + icbr_pkg::LEN_CRC) ?
                        flen - {7'd0, i_hdr} - icbr_pkg::LEN_CRC : 9'd0;
      i_apdu          = cap_apdu(i_apdu);

      if ((fb & icbr_pkg::CLS_MASK) == icbr_pkg::CLS_I) begin
         disp_seen       = 1'b1;
         disp_bn         = ~block_number_ff;
         disp_hdr2       = fb[2];
         disp_start_wait = 1'b1;
         disp_w0 = icbr_pkg::mk_word(icbr_pkg::ACT_FORWARD, fb, i_hdr, i_apdu,
                                     icbr_pkg::ST_OK);
         if (i_apdu == 9'd0) begin
            disp_two      = 1'b1;
            disp_w1       = i_reply(~block_number_ff, fb[2], 9'd0);
            disp_tx_first = disp_w1.tx_first_byte;
            disp_tx_len   = disp_w1.byte_count;
         end
      end else if ((fb & icbr_pkg::CLS_MASK) == icbr_pkg::CLS_R) begin
         if (fb[4]) begin
            // NAK: toggle only when no I-block seen and numbers match
            if ((fb[0] == block_number_ff) && !iblock_seen_ff) begin
               disp_bn = ~block_number_ff;
            end
            disp_w0 = icbr_pkg::mk_word(icbr_pkg::ACT_R_ACK, icbr_pkg::PCB_R_ACK, 2'd1,
                                        icbr_pkg::LEN_SHORT, icbr_pkg::ST_OK);
         end else begin
            disp_w0 = icbr_pkg::mk_word(icbr_pkg::ACT_RESEND, last_tx_first_ff, 2'd1,
                                        last_tx_len_ff, icbr_pkg::ST_OK);
         end
      end else if ((fb & icbr_pkg::CLS_MASK) == icbr_pkg::CLS_S) begin
         if (fb[7:4] == icbr_pkg::NIB_PPS) begin
            disp_w0 = icbr_pkg::mk_word(icbr_pkg::ACT_PPS, fb, 2'd1, icbr_pkg::LEN_SHORT,
                                        icbr_pkg::ST_OK);
         end else if ((fb == icbr_pkg::S_DESEL) ||
                      ((fb == icbr_pkg::S_DESEL_CID) && (sb == {4'd0, card_id_ff}))) begin
            disp_seen = 1'b0;
            disp_w0 = icbr_pkg::mk_word(icbr_pkg::ACT_DESELECT, fb, 2'd1,
                                        icbr_pkg::LEN_SHORT, icbr_pkg::ST_OK);
         end
      end else if (fb == icbr_pkg::CMD_ATS_REQ) begin
         disp_bn   = 1'b1;
         disp_seen = 1'b0;
         disp_cid  = sb[3:0];
         disp_w0   = icbr_pkg::mk_word(icbr_pkg::ACT_ATS, icbr_pkg::ATS_TL, 2'd1,
                                       icbr_pkg::LEN_ATS, icbr_pkg::ST_OK);
      end
   end

   // ---------------- per-word decision ----------------
   icbr_pkg::rsp_word_type w0, w1;
   logic [1:0] n_words;

   always_comb begin
      w0               = icbr_pkg::mk_report(fb, icbr_pkg::ST_OK);
      w1               = w0;
      n_words          = 2'd0;
      block_number_in  = block_number_ff;
      iblock_seen_in   = iblock_seen_ff;
      card_id_in       = card_id_ff;
      waiting_in       = waiting_ff;
      wtx_pending_in   = wtx_pending_ff;
      host_ready_in    = host_ready_ff;
      host_len_in      = host_len_ff;
      wait_count_in    = wait_count_ff;
      hdr2_in          = hdr2_ff;
      last_tx_first_in = last_tx_first_ff;
      last_tx_len_in   = last_tx_len_ff;

      if (take) begin
         case (req_ch.mode)
            icbr_pkg::MODE_FRAME: begin
               n_words = 2'd1;
               if (flen <= icbr_pkg::LEN_CRC) begin
                  w0 = icbr_pkg::mk_report(fb, icbr_pkg::ST_SHORT);
               end else if (!req_ch.crc_match) begin
                  w0 = icbr_pkg::mk_report(fb, icbr_pkg::ST_CRC);
               end else if (waiting_ff && wtx_pending_ff) begin
                  if (fb == icbr_pkg::PCB_WTX) begin
                     wtx_pending_in = 1'b0;
                     wait_count_in  = wtx_interval_ff;
                     if (host_ready_ff) begin
                        waiting_in       = 1'b0;
                        host_ready_in    = 1'b0;
                        w0               = i_reply(block_number_ff, hdr2_ff, host_len_ff);
                        last_tx_first_in = w0.tx_first_byte;
                        last_tx_len_in   = w0.byte_count;
                     end else begin
                        w0 = icbr_pkg::mk_report(fb, icbr_pkg::ST_OK);
                     end
                  end else begin
                     waiting_in     = 1'b0;
                     wtx_pending_in = 1'b0;
                     host_ready_in  = 1'b0;
                     w0             = icbr_pkg::mk_report(fb, icbr_pkg::ST_NAK);
                  end
               end else if (waiting_ff) begin
                  if (fb[7:4] == icbr_pkg::NIB_R_NAK) begin
                     // abort report, then the NAK is handled as an R-block
                     waiting_in     = 1'b0;
                     wtx_pending_in = 1'b0;
                     host_ready_in  = 1'b0;
                     w0             = icbr_pkg::mk_report(fb, icbr_pkg::ST_NAK);
                     w1             = disp_w0;
                     n_words        = 2'd2;
                     block_number_in = disp_bn;
                     iblock_seen_in  = disp_seen;
                  end else begin
                     w0 = icbr_pkg::mk_report(fb, icbr_pkg::ST_STRAY);
                  end
               end else begin
                  w0               = disp_w0;
                  w1               = disp_w1;
                  n_words          = disp_two ? 2'd2 : 2'd1;
                  block_number_in  = disp_bn;
                  iblock_seen_in   = disp_seen;
                  card_id_in       = disp_cid;
                  hdr2_in          = disp_hdr2;
                  last_tx_first_in = disp_tx_first;
                  last_tx_len_in   = disp_tx_len;
                  if (disp_start_wait) begin
                     waiting_in     = 1'b1;
                     wtx_pending_in = 1'b0;
                     host_ready_in  = 1'b0;
                     wait_count_in  = {1'b0, wtx_interval_ff[15:1]};
                  end
               end
            end
            icbr_pkg::MODE_HOST: begin
               if (waiting_ff && wtx_pending_ff) begin
                  host_ready_in = 1'b1;
                  host_len_in   = cap_apdu(req_ch.host_length);
               end else if (waiting_ff) begin
                  waiting_in       = 1'b0;
                  wtx_pending_in   = 1'b0;
                  host_ready_in    = 1'b0;
                  w0               = i_reply(block_number_ff, hdr2_ff, req_ch.host_length);
                  last_tx_first_in = w0.tx_first_byte;
                  last_tx_len_in   = w0.byte_count;
                  n_words          = 2'd1;
               end else begin
                  w0      = icbr_pkg::mk_report(fb, icbr_pkg::ST_IGNORED);
                  n_words = 2'd1;
               end
            end
            icbr_pkg::MODE_TICK: begin
               if (waiting_ff && !wtx_pending_ff) begin
                  if (wait_count_ff == 16'd0) begin
                     wtx_pending_in = 1'b1;
                     w0 = icbr_pkg::mk_word(icbr_pkg::ACT_WTX, icbr_pkg::PCB_WTX, 2'd1,
                                            icbr_pkg::LEN_WTX, icbr_pkg::ST_OK);
                     n_words = 2'd1;
                  end else begin
                     wait_count_in = wait_count_ff - 16'd1;
                  end
               end
            end
            default: begin
               n_words = 2'd0;
            end
         endcase
      end

      w0.last = (n_words == 2'd1);
      w1.last = 1'b1;

      wr_ptr_in = wr_ptr_ff + n_words;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, n_words} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_number_ff  <= 1'b1;
         iblock_seen_ff   <= 1'b0;
         card_id_ff       <= 4'd0;
         waiting_ff       <= 1'b0;
         wtx_pending_ff   <= 1'b0;
         host_ready_ff    <= 1'b0;
         host_len_ff      <= 9'd0;
         wait_count_ff    <= 16'd0;
         hdr2_ff          <= 1'b0;
         last_tx_first_ff <= 8'd0;
         last_tx_len_ff   <= 9'd0;
         wr_ptr_ff        <= 2'd0;
         rd_ptr_ff        <= 2'd0;
         count_ff         <= 3'd0;
      end else begin
         block_number_ff  <= block_number_in;
         iblock_seen_ff   <= iblock_seen_in;
         card_id_ff       <= card_id_in;
         waiting_ff       <= waiting_in;
         wtx_pending_ff   <= wtx_pending_in;
         host_ready_ff    <= host_ready_in;
         host_len_ff      <= host_len_in;
         wait_count_ff    <= wait_count_in;
         hdr2_ff          <= hdr2_in;
         last_tx_first_ff <= last_tx_first_in;
         last_tx_len_ff   <= last_tx_len_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         count_ff         <= count_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (n_words != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= w0;
      end
      if (n_words == 2'd2) begin
         fifo_ff[wr_ptr_ff + 2'd1] <= w1;
      end
   end

   assign rsp_ch.valid          = (count_ff != 3'd0);
   assign rsp_ch.action         = fifo_ff[rd_ptr_ff].action;
   assign rsp_ch.tx_first_byte  = fifo_ff[rd_ptr_ff].tx_first_byte;
   assign rsp_ch.payload_offset = fifo_ff[rd_ptr_ff].payload_offset;
   assign rsp_ch.byte_count     = fifo_ff[rd_ptr_ff].byte_count;
   assign rsp_ch.status         = fifo_ff[rd_ptr_ff].status;
   assign rsp_ch.last           = fifo_ff[rd_ptr_ff].last;

endmodule

FILE: hw/rtl/icbr_checker.sv
module icbr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_action,
   input logic [1:0] rsp_payload_offset,
   input logic [8:0] rsp_byte_count,
   input logic [2:0] rsp_status
);

   // a stalled word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn while stalled");

   // nothing offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word offered after reset");

   // only reports carry a non-ok status
   a_status_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != icbr_pkg::ST_OK) |-> rsp_action == icbr_pkg::ACT_REPORT)
      else $error("error status on a transmit command");

   // two-byte header only on forwarded APDUs and I replies
   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload_offset != 2'd1) |->
         (rsp_action == icbr_pkg::ACT_FORWARD) || (rsp_action == icbr_pkg::ACT_I_REPLY))
      else $error("unexpected payload offset");

   // reports never carry a byte count
   a_report_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == icbr_pkg::ACT_REPORT) |-> rsp_byte_count == 9'd0)
      else $error("report with non-zero byte count");

endmodule

bind iso14443_4_card_block_responder icbr_checker u_icbr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_action         (rsp_ch.action),
   .rsp_payload_offset (rsp_ch.payload_offset),
   .rsp_byte_count     (rsp_ch.byte_count),
   .rsp_status         (rsp_ch.status)
);
